@@ design/assert_macros.svh @@
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/hsbyc_pkg.sv @@
package hsbyc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ROLES   = 3'd0;
    localparam logic [2:0] CFG_RADIX_0 = 3'd1;
    localparam logic [2:0] CFG_RADIX_1 = 3'd2;
    localparam logic [2:0] CFG_RADIX_2 = 3'd3;
    localparam logic [2:0] CFG_OFFS_0  = 3'd4;
    localparam logic [2:0] CFG_OFFS_1  = 3'd5;
    localparam logic [2:0] CFG_OFFS_2  = 3'd6;

    // Digit role codes.
    localparam logic [1:0] ROLE_HUE = 2'd0;
    localparam logic [1:0] ROLE_SAT = 2'd1;
    localparam logic [1:0] ROLE_BRI = 2'd2;
    localparam logic [1:0] ROLE_BAD = 2'd3;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // BT.601 weights in Q.16, summing to one.
    localparam int W_R = 19595;
    localparam int W_G = 38470;
    localparam int W_B = 7471;

    // 1/1.772 = 250/443 and 1/1.402 = 500/701.
    localparam int CB_NUM = 250;
    localparam int CB_DEN = 443;
    localparam int CR_NUM = 500;
    localparam int CR_DEN = 701;

    // Rounded-up reciprocals of the chroma denominators: floor(h * M / 2^30)
    // equals floor(h / den) for every 20-bit h.
    localparam int          RECIP_SHIFT = 30;
    localparam logic [21:0] CB_RECIP    = 22'd2423797;
    localparam logic [21:0] CR_RECIP    = 22'd1531729;

endpackage

@@ design/hsbyc_div_pipe.sv @@
module hsbyc_div_pipe #(
    parameter int NUM_W  = 16,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [7:0]        i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [7:0]        o_rem,
    output logic [SIDE_W-1:0] o_side
);
    localparam int STEP   = 4;
    localparam int STAGES = (NUM_W + STEP - 1) / STEP;
    localparam int PAD_W  = STAGES * STEP;

    logic [PAD_W-1:0]  r_acc  [STAGES];
    logic [7:0]        r_rem  [STAGES];
    logic [SIDE_W-1:0] r_side [STAGES];
    logic [STAGES-1:0] r_vld;

    // The user keeps the divisor fixed while words are in flight; stages read it directly.
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [PAD_W-1:0]  acc_in;
        logic [7:0]        rem_in;
        logic [SIDE_W-1:0] side_in;
        logic              v_in;
        logic [PAD_W-1:0]  n_acc;
        logic [7:0]        n_rem;

        if (s == 0) begin : g_first
            assign acc_in  = PAD_W'(i_num);
            assign rem_in  = '0;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign acc_in  = r_acc[s-1];
            assign rem_in  = r_rem[s-1];
            assign side_in = r_side[s-1];
            assign v_in    = r_vld[s-1];
        end

        always_comb begin
            logic [8:0] t;
            n_acc = acc_in;
            n_rem = rem_in;
            for (int k = 0; k < STEP; k++) begin
                t     = {n_rem, n_acc[PAD_W-1]};
                n_acc = n_acc << 1;
                if (t >= {1'b0, i_den}) begin
                    n_rem    = 8'(t - {1'b0, i_den});
                    n_acc[0] = 1'b1;
                end else begin
                    n_rem = t[7:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[s]  <= n_acc;
                r_rem[s]  <= n_rem;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quot  = r_acc[STAGES-1][NUM_W-1:0];
    assign o_rem   = r_rem[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

@@ design/hsb_palette_to_ycbcr_top.sv @@
// Palette color generator: turns a color index into one YCbCr color.
// Input: i_valid / o_ready carry i_color_index, one word per cycle while o_ready is high.
// Output channel: o_valid / i_ready carry luma, signed Cb and Cr and the
// bad_roles flag, one word for every accepted index, in order.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_idx
// in the same cycle; write only while no word is in flight.
// The pipeline is three chained digit dividers that retire four quotient bits per
// stage, three parallel fraction dividers of six stages, and eleven stages of
// color arithmetic.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and o_ready drops; no
// word is dropped or repeated. Reset empties the pipeline and loads the
// register defaults: hue from the first digit with radix 16, other radices 1.
`include "assert_macros.svh"

module hsb_palette_to_ycbcr_top #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [INDEX_BITS-1:0] i_color_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_luma,
    output logic signed [8:0]     o_chroma_blue,
    output logic signed [8:0]     o_chroma_red,
    output logic                  o_bad_roles,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    import hsbyc_pkg::*;

    logic [5:0]  r_roles;
    logic [7:0]  r_rad0, r_rad1, r_rad2;
    logic [15:0] r_off0, r_off1, r_off2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roles <= 6'd36;
            r_rad0  <= 8'd16;
            r_rad1  <= 8'd1;
            r_rad2  <= 8'd1;
            r_off0  <= '0;
            r_off1  <= '0;
            r_off2  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROLES:   r_roles <= i_cfg_data[5:0];
                CFG_RADIX_0: r_rad0  <= i_cfg_data[7:0];
                CFG_RADIX_1: r_rad1  <= i_cfg_data[7:0];
                CFG_RADIX_2: r_rad2  <= i_cfg_data[7:0];
                CFG_OFFS_0:  r_off0  <= i_cfg_data;
                CFG_OFFS_1:  r_off1  <= i_cfg_data;
                CFG_OFFS_2:  r_off2  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A radix of zero acts as one.
    logic [7:0] rd0, rd1, rd2;
    assign rd0 = (r_rad0 == 8'd0) ? 8'd1 : r_rad0;
    assign rd1 = (r_rad1 == 8'd0) ? 8'd1 : r_rad1;
    assign rd2 = (r_rad2 == 8'd0) ? 8'd1 : r_rad2;

    logic en;
    logic r_k_vld;
    assign en      = !r_k_vld || i_ready;
    assign o_ready = en;

    // Digit extraction.
    logic                  v1, v2, vf;
    logic [INDEX_BITS-1:0] x1, x2;
    logic [7:0]            q0, q1, q2, s1_q0;
    logic [15:0]           s2_q;

    hsbyc_div_pipe #(.NUM_W(INDEX_BITS), .SIDE_W(1)) u_dig0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_num(i_color_index), .i_den(rd0), .i_side(1'b0),
        .o_valid(v1), .o_quot(x1), .o_rem(q0), .o_side()
    );
    hsbyc_div_pipe #(.NUM_W(INDEX_BITS), .SIDE_W(8)) u_dig1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v1),
        .i_num(x1), .i_den(rd1), .i_side(q0),
        .o_valid(v2), .o_quot(x2), .o_rem(q1), .o_side(s1_q0)
    );

    // Digit fractions, floor(digit * 2^16 / radix), in parallel.
    logic        v_d2;
    logic [23:0] fq0, fq1, fq2;

    hsbyc_div_pipe #(.NUM_W(INDEX_BITS), .SIDE_W(16)) u_dig2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v2),
        .i_num(x2), .i_den(rd2), .i_side({s1_q0, q1}),
        .o_valid(v_d2), .o_quot(), .o_rem(q2), .o_side(s2_q)
    );

    hsbyc_div_pipe #(.NUM_W(24), .SIDE_W(1)) u_frac0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v_d2),
        .i_num({s2_q[15:8], 16'd0}), .i_den(rd0), .i_side(1'b0),
        .o_valid(vf), .o_quot(fq0), .o_rem(), .o_side()
    );
    hsbyc_div_pipe #(.NUM_W(24), .SIDE_W(1)) u_frac1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v_d2),
        .i_num({s2_q[7:0], 16'd0}), .i_den(rd1), .i_side(1'b0),
        .o_valid(), .o_quot(fq1), .o_rem(), .o_side()
    );
    hsbyc_div_pipe #(.NUM_W(24), .SIDE_W(1)) u_frac2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v_d2),
        .i_num({q2, 16'd0}), .i_den(rd2), .i_side(1'b0),
        .o_valid(), .o_quot(fq2), .o_rem(), .o_side()
    );

    // Stage A: add offsets, wrap past one, route to components and flag bad roles.
    logic [16:0] n_a_h, n_a_s, n_a_br;
    logic        n_a_bad;
    always_comb begin
        logic [16:0] f [3];
        logic [1:0]  role;
        f[0] = {1'b0, fq0[15:0]} + {1'b0, r_off0};
        f[1] = {1'b0, fq1[15:0]} + {1'b0, r_off1};
        f[2] = {1'b0, fq2[15:0]} + {1'b0, r_off2};
        n_a_h   = '0;
        n_a_s   = '0;
        n_a_br  = '0;
        n_a_bad = 1'b0;
        for (int d = 0; d < 3; d++) begin
            if (f[d] > ONE_Q16) begin
                f[d] = f[d] - ONE_Q16;
            end
            role = r_roles[2*d +: 2];
            case (role)
                ROLE_HUE: n_a_h   = f[d];
                ROLE_SAT: n_a_s   = f[d];
                ROLE_BRI: n_a_br  = f[d];
                default:  n_a_bad = 1'b1;
            endcase
        end
    end

    logic [16:0] r_a_h, r_a_s, r_a_br;
    logic        r_a_bad;

    // Stage B: hue ramp and 1 - brightness.
    logic [16:0] n_b_rr, n_b_rg, n_b_rb;
    always_comb begin
        logic [18:0] t;
        t = 19'({r_a_h, 1'b0}) + 19'(r_a_h);
        if (t < 19'(ONE_Q16)) begin
            n_b_rr = 17'(19'(ONE_Q16) - t);
            n_b_rg = 17'(t);
            n_b_rb = '0;
        end else if (t > 19'({ONE_Q16, 1'b0})) begin
            n_b_rr = 17'(t - 19'({ONE_Q16, 1'b0}));
            n_b_rg = '0;
            n_b_rb = 17'(19'(ONE_Q16) + 19'({ONE_Q16, 1'b0}) - t);
        end else begin
            n_b_rr = '0;
            n_b_rg = 17'(19'({ONE_Q16, 1'b0}) - t);
            n_b_rb = 17'(t - 19'(ONE_Q16));
        end
    end

    logic [16:0] r_b_rr, r_b_rg, r_b_rb, r_b_s, r_b_om, r_b_br;
    logic        r_b_bad;
    logic [32:0] r_c_p1;
    logic [16:0] r_c_rr, r_c_rg, r_c_rb, r_c_br;
    logic        r_c_bad;
    logic [49:0] r_d_pr, r_d_pg, r_d_pb;
    logic [16:0] r_d_br;
    logic        r_d_bad;
    logic [16:0] r_e_r, r_e_g, r_e_b;
    logic        r_e_bad;
    logic [32:0] r_f_ws;
    logic [16:0] r_f_r, r_f_b;
    logic        r_f_bad;
    logic [39:0] r_g_y32, r_g_bs, r_g_rs;
    logic        r_g_bad;
    logic signed [41:0] r_h_db, r_h_dr;
    logic [7:0]  r_h_luma;
    logic        r_h_bad;
    logic signed [51:0] r_i_tb, r_i_tr;
    logic [7:0]  r_i_luma;
    logic        r_i_bad;
    logic        r_j_sb, r_j_sr;
    logic [19:0] r_j_hb, r_j_hr;
    logic [7:0]  r_j_luma;
    logic        r_j_bad;
    logic [9:0]  r_vld;

    logic [51:0] mag_b, mag_r;
    logic [41:0] prod_b, prod_r;
    logic [7:0]  q_b, q_r;
    assign mag_b  = r_i_tb[51] ? 52'(-r_i_tb) : 52'(r_i_tb);
    assign mag_r  = r_i_tr[51] ? 52'(-r_i_tr) : 52'(r_i_tr);
    // Division by the constant denominators as one reciprocal multiplication.
    assign prod_b = 42'(r_j_hb) * 42'(CB_RECIP);
    assign prod_r = 42'(r_j_hr) * 42'(CR_RECIP);
    assign q_b    = prod_b[RECIP_SHIFT +: 8];
    assign q_r    = prod_r[RECIP_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_k_vld <= 1'b0;
        end else if (en) begin
            r_vld   <= {r_vld[8:0], vf};
            r_k_vld <= r_vld[9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_h   <= n_a_h;
            r_a_s   <= n_a_s;
            r_a_br  <= n_a_br;
            r_a_bad <= n_a_bad;

            r_b_rr  <= n_b_rr;
            r_b_rg  <= n_b_rg;
            r_b_rb  <= n_b_rb;
            r_b_s   <= r_a_s;
            r_b_om  <= ONE_Q16 - r_a_br;
            r_b_br  <= r_a_br;
            r_b_bad <= r_a_bad;

            r_c_p1  <= 33'(34'(r_b_s) * 34'(r_b_om));
            r_c_rr  <= r_b_rr;
            r_c_rg  <= r_b_rg;
            r_c_rb  <= r_b_rb;
            r_c_br  <= r_b_br;
            r_c_bad <= r_b_bad;

            r_d_pr  <= 50'(r_c_rr) * 50'(r_c_p1);
            r_d_pg  <= 50'(r_c_rg) * 50'(r_c_p1);
            r_d_pb  <= 50'(r_c_rb) * 50'(r_c_p1);
            r_d_br  <= r_c_br;
            r_d_bad <= r_c_bad;

            r_e_r   <= r_d_br + r_d_pr[48:32];
            r_e_g   <= r_d_br + r_d_pg[48:32];
            r_e_b   <= r_d_br + r_d_pb[48:32];
            r_e_bad <= r_d_bad;

            r_f_ws  <= 33'(33'(W_R) * 33'(r_e_r) + 33'(W_G) * 33'(r_e_g)
                           + 33'(W_B) * 33'(r_e_b));
            r_f_r   <= r_e_r;
            r_f_b   <= r_e_b;
            r_f_bad <= r_e_bad;

            // Times 255 as a shift and a subtract.
            r_g_y32 <= (40'(r_f_ws) << 8) - 40'(r_f_ws);
            r_g_bs  <= ((40'(r_f_b) << 8) - 40'(r_f_b)) << 16;
            r_g_rs  <= ((40'(r_f_r) << 8) - 40'(r_f_r)) << 16;
            r_g_bad <= r_f_bad;

            r_h_db   <= $signed({2'b00, r_g_bs}) - $signed({2'b00, r_g_y32});
            r_h_dr   <= $signed({2'b00, r_g_rs}) - $signed({2'b00, r_g_y32});
            r_h_luma <= r_g_y32[39:32];
            r_h_bad  <= r_g_bad;

            // Scaled chroma plus one half, both over den * 2^32.
            r_i_tb   <= 52'(r_h_db) * 52'(CB_NUM) + (52'(CB_DEN) <<< 31);
            r_i_tr   <= 52'(r_h_dr) * 52'(CR_NUM) + (52'(CR_DEN) <<< 31);
            r_i_luma <= r_h_luma;
            r_i_bad  <= r_h_bad;

            // Dropping the low 32 bits of the magnitude first leaves the quotient unchanged.
            r_j_sb   <= r_i_tb[51];
            r_j_sr   <= r_i_tr[51];
            r_j_hb   <= mag_b[51:32];
            r_j_hr   <= mag_r[51:32];
            r_j_luma <= r_i_luma;
            r_j_bad  <= r_i_bad;

            o_luma        <= r_j_luma;
            o_chroma_blue <= r_j_sb ? -$signed({1'b0, q_b}) : $signed({1'b0, q_b});
            o_chroma_red  <= r_j_sr ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
            o_bad_roles   <= r_j_bad;
        end
    end

    assign o_valid = r_k_vld;

    logic any_bad;
    assign any_bad = (r_roles[1:0] == ROLE_BAD) || (r_roles[3:2] == ROLE_BAD)
                     || (r_roles[5:4] == ROLE_BAD);

    `ASSERT_CLK(a_reset_empties, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")
    `ASSERT_CLKD(a_bad_flag, i_clk, i_rst_n, o_valid |-> (o_bad_roles == any_bad), "bad_roles mismatch")
    `ASSERT_CLKD(a_chroma_range, i_clk, i_rst_n, o_valid |-> (o_chroma_blue >= -9'sd128 && o_chroma_blue <= 9'sd128 && o_chroma_red >= -9'sd128 && o_chroma_red <= 9'sd128), "chroma out of range")

endmodule

@@ sim/hsb_palette_to_ycbcr_top_tb.sv @@
`timescale 1ns / 100ps

module hsb_palette_to_ycbcr_top_tb;
    import hsbyc_pkg::*;

    localparam int LATENCY   = 29;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1600;

    typedef struct packed {
        logic [7:0]        luma;
        logic signed [8:0] cb;
        logic signed [8:0] cr;
        logic              bad;
    } t_color;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [15:0]        i_color_index = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [7:0]         o_luma;
    logic signed [8:0]  o_chroma_blue;
    logic signed [8:0]  o_chroma_red;
    logic               o_bad_roles;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;

    hsb_palette_to_ycbcr_top dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [5:0]  roles_q;
    logic [7:0]  radix_q [3];
    logic [15:0] offs_q  [3];

    logic [15:0] pending_idx[$];
    t_color      expected_colors[$];
    int          n_errors = 0;
    int          wdog = 0;
    bit          quiet = 1'b0;   // no idling near the end
    int          send_gap = 0;
    int          recv_gap = 0;

    function automatic t_color predict_color(input logic [15:0] idx);
        longint unsigned x, rd, q, f, t, y32;
        longint unsigned comp[3];
        longint unsigned ramp[3];
        longint unsigned ch[3];
        longint signed diff, top;
        logic [1:0] role;
        t_color c;
        x = idx;
        comp = '{0, 0, 0};
        c.bad = 1'b0;
        for (int d = 0; d < 3; d++) begin
            rd = (radix_q[d] == 0) ? 1 : radix_q[d];
            q = x % rd;
            f = ((q << 16) / rd) + offs_q[d];
            x = x / rd;
            if (f > 65536) f -= 65536;
            role = roles_q[2*d +: 2];
            if (role == ROLE_BAD) c.bad = 1'b1;
            else comp[role] = f;
        end
        t = 3 * comp[ROLE_HUE];
        if (t < 65536) begin
            ramp = '{65536 - t, t, 0};
        end else if (t > 131072) begin
            ramp = '{t - 131072, 0, 196608 - t};
        end else begin
            ramp = '{0, 131072 - t, t - 65536};
        end
        for (int k = 0; k < 3; k++)
            ch[k] = comp[ROLE_BRI] +
                    ((ramp[k] * comp[ROLE_SAT] * (65536 - comp[ROLE_BRI])) >> 32);
        y32 = (19595 * ch[0] + 38470 * ch[1] + 7471 * ch[2]) * 255;
        c.luma = 8'(y32 >> 32);
        diff = longint'(ch[2] * 255 * 65536) - longint'(y32);
        top = diff * CB_NUM + longint'(CB_DEN) * (longint'(1) << 31);
        c.cb = 9'(top / (longint'(CB_DEN) * (longint'(1) << 32)));
        diff = longint'(ch[0] * 255 * 65536) - longint'(y32);
        top = diff * CR_NUM + longint'(CR_DEN) * (longint'(1) << 31);
        c.cr = 9'(top / (longint'(CR_DEN) * (longint'(1) << 32)));
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        n_errors++;
    endtask

    // Driver: one word per cycle if queued, o_ready is high and no gap runs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_colors.push_back(predict_color(i_color_index));
                void'(pending_idx.pop_front());
            end
            if (i_valid && !o_ready) begin
                // hold the word
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if ((pending_idx.size() > (i_valid && o_ready ? 0 : 0)) &&
                         pending_idx.size() != 0) begin
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_color_index <= pending_idx[0];
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor with random receiver stalls.
    always @(posedge i_clk) begin
        t_color exp_c;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    exp_c = expected_colors.pop_front();
                    if (o_luma !== exp_c.luma)
                        report_mismatch("luma", o_luma, exp_c.luma);
                    if (o_chroma_blue !== exp_c.cb)
                        report_mismatch("chroma_blue", o_chroma_blue, exp_c.cb);
                    if (o_chroma_red !== exp_c.cr)
                        report_mismatch("chroma_red", o_chroma_red, exp_c.cr);
                    if (o_bad_roles !== exp_c.bad)
                        report_mismatch("bad_roles", o_bad_roles, exp_c.bad);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 7);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ROLES:   roles_q    = val[5:0];
            CFG_RADIX_0: radix_q[0] = val[7:0];
            CFG_RADIX_1: radix_q[1] = val[7:0];
            CFG_RADIX_2: radix_q[2] = val[7:0];
            CFG_OFFS_0:  offs_q[0]  = val;
            CFG_OFFS_1:  offs_q[1]  = val;
            CFG_OFFS_2:  offs_q[2]  = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_idx.size() == 0 && !i_valid);
        wait (expected_colors.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic config_all(input logic [5:0] roles, input logic [7:0] r0,
                              input logic [7:0] r1, input logic [7:0] r2,
                              input logic [15:0] f0, input logic [15:0] f1,
                              input logic [15:0] f2);
        write_reg(CFG_ROLES, {10'd0, roles});
        write_reg(CFG_RADIX_0, {8'd0, r0});
        write_reg(CFG_RADIX_1, {8'd0, r1});
        write_reg(CFG_RADIX_2, {8'd0, r2});
        write_reg(CFG_OFFS_0, f0);
        write_reg(CFG_OFFS_1, f1);
        write_reg(CFG_OFFS_2, f2);
    endtask

    initial begin
        roles_q = 6'd36;
        radix_q = '{8'd16, 8'd1, 8'd1};
        offs_q  = '{16'd0, 16'd0, 16'd0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, field extremes.
        pending_idx.push_back(16'h0000);
        pending_idx.push_back(16'hFFFF);
        pending_idx.push_back(16'h0005);
        pending_idx.push_back(16'h000A);
        drain();

        // Hue, saturation, brightness on separate digits; wrap offsets.
        config_all({ROLE_BRI, ROLE_SAT, ROLE_HUE}, 8'd6, 8'd4, 8'd5,
                   16'hFFFF, 16'h8000, 16'h0001);
        for (int i = 0; i < 8; i++) pending_idx.push_back(16'($urandom_range(0, 119)));
        pending_idx.push_back(16'hFFFF);
        drain();

        // Illegal role, duplicated role, unset component, radix zero and max.
        config_all({ROLE_HUE, ROLE_BAD, ROLE_HUE}, 8'd0, 8'd255, 8'd255,
                   16'd0, 16'hFFFF, 16'd0);
        pending_idx.push_back(16'h0000);
        pending_idx.push_back(16'h1234);
        pending_idx.push_back(16'hFFFF);
        pending_idx.push_back(16'h00FF);
        drain();
        config_all({ROLE_BAD, ROLE_BAD, ROLE_BAD}, 8'd1, 8'd1, 8'd1,
                   16'd0, 16'd0, 16'd0);
        pending_idx.push_back(16'h5555);
        drain();

        // Random phases with random configurations; the pause between phases
        // lets every expected word come back before the next write.
        for (int p = 0; p < 8; p++) begin
            config_all(6'($urandom), 8'($urandom), 8'($urandom_range(1, 16)),
                       8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            if (p == 7) quiet = 1'b1;
            for (int i = 0; i < N_RANDOM / 8; i++)
                pending_idx.push_back(16'($urandom));
            drain();
        end

        if (n_errors == 0 && expected_colors.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/hsbyc_pkg.sv
design/hsbyc_div_pipe.sv
design/hsb_palette_to_ycbcr_top.sv
sim/hsb_palette_to_ycbcr_top_tb.sv
